// ----- rtl/mips_subset_execute_unit_macros.svh -----
// Assertion helpers for the execute unit.
`ifndef MIPS_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define MSEU_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, once seen, implies another at the next edge.
`define MSEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mseu_pkg.sv -----
`default_nettype none
package mseu_pkg;

    typedef enum logic [5:0] {
        OP_ADD     = 6'd0,
        OP_ADDU    = 6'd1,
        OP_SUB     = 6'd2,
        OP_AND     = 6'd3,
        OP_OR      = 6'd4,
        OP_XOR     = 6'd5,
        OP_NOR     = 6'd6,
        OP_NAND    = 6'd7,
        OP_SLT     = 6'd8,
        OP_SLL     = 6'd9,
        OP_SRL     = 6'd10,
        OP_SRA     = 6'd11,
        OP_JR      = 6'd12,
        OP_MULT    = 6'd13,
        OP_MULTU   = 6'd14,
        OP_MFHI    = 6'd15,
        OP_MFLO    = 6'd16,
        OP_ADDI    = 6'd17,
        OP_ADDIU   = 6'd18,
        OP_LW      = 6'd19,
        OP_LH      = 6'd20,
        OP_LHU     = 6'd21,
        OP_LB      = 6'd22,
        OP_LBU     = 6'd23,
        OP_SW      = 6'd24,
        OP_SH      = 6'd25,
        OP_SB      = 6'd26,
        OP_LUI     = 6'd27,
        OP_ANDI    = 6'd28,
        OP_ORI     = 6'd29,
        OP_NORI    = 6'd30,
        OP_SLTI    = 6'd31,
        OP_BEQ     = 6'd32,
        OP_BNE     = 6'd33,
        OP_BGTZ    = 6'd34,
        OP_J       = 6'd35,
        OP_JAL     = 6'd36,
        OP_PRELOAD = 6'd37,
        OP_START   = 6'd38
    } t_op;

    typedef enum logic [2:0] {
        CK_NONE,
        CK_REG,
        CK_LOAD,
        CK_STORE,
        CK_PRELOAD,
        CK_START
    } t_ckind;

    localparam logic [4:0]  SP_REG    = 5'd29;
    localparam logic [4:0]  RA_REG    = 5'd31;
    localparam logic [31:0] SP_RESET  = 32'd1024;
    localparam int          OUT_DEPTH = 4;

    typedef struct packed {
        logic [5:0]         req_type;
        logic [4:0]         src_a_index;
        logic [4:0]         src_b_index;
        logic [4:0]         dest_index;
        logic [4:0]         shift_amount;
        logic signed [15:0] immediate;
        logic [25:0]        jump_target;
        logic [7:0]         preload_address;
        logic [31:0]        preload_word;
    } t_item;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        pc_redirected;
        logic [31:0] effective_address;
        logic        halted;
        logic        err_write_zero;
        logic        err_overflow;
        logic        err_hilo_overwrite;
        logic        err_address_range;
        logic        err_misaligned;
    } t_result;

    typedef struct packed {
        logic        en;
        logic        start;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

endpackage
`default_nettype wire

// ----- rtl/mseu_regfile.sv -----
`default_nettype none
module mseu_regfile
    import mseu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rd_en,
    input  wire logic [4:0]  i_rd_addr_a,
    input  wire logic [4:0]  i_rd_addr_b,
    input  wire t_rf_wr      i_wr,
    output logic      [31:0] o_rd_data_a,
    output logic      [31:0] o_rd_data_b
);

    logic [31:0] r_regs [32];
    logic [31:0] r_valid;
    logic [31:0] r_qa;
    logic [31:0] r_qb;
    logic        r_va;
    logic        r_vb;

    // An entry that is not valid reads as zero, so a start clears the file at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.start) begin
            r_valid <= 32'd1 << SP_REG;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.start) begin
            r_regs[SP_REG] <= i_wr.data;
        end else if (i_wr.en) begin
            r_regs[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_qa <= r_regs[i_rd_addr_a];
            r_qb <= r_regs[i_rd_addr_b];
            r_va <= r_valid[i_rd_addr_a];
            r_vb <= r_valid[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_va ? r_qa : 32'd0;
    assign o_rd_data_b = r_vb ? r_qb : 32'd0;

endmodule
`default_nettype wire

// ----- rtl/mips_subset_execute_unit.sv -----
// Executes one decoded instruction per transaction and takes a new one every cycle
// while the output queue has room and no memory clear runs. An item is read from the
// register file in the cycle it is accepted, executed in the next cycle, where its
// result is queued for the output, and finishes its load or store in the data memory
// in the cycle after; register and memory values are forwarded between these steps,
// so dependent items follow each other without a gap. A four-entry output queue holds
// results while the consumer stalls. After reset the data memory is cleared one word
// a cycle, and no item is accepted until every word is clear.
`default_nettype none
`include "mips_subset_execute_unit_macros.svh"
module mips_subset_execute_unit
    import mseu_pkg::*;
#(
    parameter int MEM_BYTES = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic        [31:0] i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic        [5:0]  i_req_type,
    input  wire logic        [4:0]  i_src_a_index,
    input  wire logic        [4:0]  i_src_b_index,
    input  wire logic        [4:0]  i_dest_index,
    input  wire logic        [4:0]  i_shift_amount,
    input  wire logic signed [15:0] i_immediate,
    input  wire logic        [25:0] i_jump_target,
    input  wire logic        [7:0]  i_preload_address,
    input  wire logic        [31:0] i_preload_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic             [31:0] o_next_pc,
    output logic                    o_pc_redirected,
    output logic             [31:0] o_effective_address,
    output logic                    o_halted,
    output logic                    o_err_write_zero,
    output logic                    o_err_overflow,
    output logic                    o_err_hilo_overwrite,
    output logic                    o_err_address_range,
    output logic                    o_err_misaligned
);

    localparam int MEM_WORDS = (MEM_BYTES + 3) / 4;
    localparam int IDXW      = $clog2(MEM_WORDS);
    localparam int PTRW      = $clog2(OUT_DEPTH);
    localparam int CNTW      = $clog2(OUT_DEPTH + 1);

    logic [31:0] r_pc_start;
    logic [31:0] r_sp_start;
    logic [31:0] r_pc, n_pc;
    logic [31:0] r_hi, n_hi;
    logic [31:0] r_lo, n_lo;
    logic        r_mp, n_mp;
    logic        r_halt, n_halt;

    logic        r_clear_active;
    logic [IDXW-1:0] r_clear_idx;

    logic        in_acc;
    logic        r_b_valid;
    t_item       r_b;

    t_ckind      r_c_kind, n_c_kind;
    logic [5:0]  r_c_op, n_c_op;
    logic [4:0]  r_c_addr, n_c_addr;
    logic [31:0] r_c_data, n_c_data;
    logic [1:0]  r_c_ealo, n_c_ealo;
    logic [IDXW-1:0] r_c_idx, n_c_idx;

    t_rf_wr      c_wr;
    t_rf_wr      r_d_wr;
    logic [31:0] rf_a;
    logic [31:0] rf_b;

    logic [31:0] r_dmem [MEM_WORDS];
    logic [31:0] r_mem_q;
    logic        mem_rd;
    logic        r_dm_valid;
    logic [IDXW-1:0] r_dm_idx;
    logic [31:0] r_dm_data;
    logic        mem_we;
    logic [IDXW-1:0] mem_waddr;
    logic [31:0] mem_wdata;

    t_result     res;
    t_result     r_fifo [OUT_DEPTH];
    logic [PTRW-1:0] r_wr_ptr;
    logic [PTRW-1:0] r_rd_ptr;
    logic [CNTW-1:0] r_count;
    logic        out_acc;

    function automatic logic [31:0] fwd(input logic [4:0] idx, input logic [31:0] raw,
                                        input t_rf_wr c, input t_rf_wr d);
        logic [31:0] v;
        v = raw;
        if (d.start) begin
            v = (idx == SP_REG) ? d.data : 32'd0;
        end else if (d.en && d.addr == idx) begin
            v = d.data;
        end
        if (c.start) begin
            v = (idx == SP_REG) ? c.data : 32'd0;
        end else if (c.en && c.addr == idx) begin
            v = c.data;
        end
        return v;
    endfunction

    assign o_in_ready = !r_clear_active && ((r_count + CNTW'(r_b_valid)) < CNTW'(OUT_DEPTH));
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc_start <= '0;
            r_sp_start <= SP_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index) begin
                r_sp_start <= i_cfg_data;
            end else begin
                r_pc_start <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b <= '{req_type: i_req_type, src_a_index: i_src_a_index,
                     src_b_index: i_src_b_index, dest_index: i_dest_index,
                     shift_amount: i_shift_amount, immediate: i_immediate,
                     jump_target: i_jump_target, preload_address: i_preload_address,
                     preload_word: i_preload_word};
        end
    end

    mseu_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_acc),
        .i_rd_addr_a (i_src_a_index),
        .i_rd_addr_b (i_src_b_index),
        .i_wr        (c_wr),
        .o_rd_data_a (rf_a),
        .o_rd_data_b (rf_b)
    );

    // Execute step.
    always_comb begin
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] pc4;
        logic [31:0] npc;
        logic [31:0] simm;
        logic [31:0] zimm;
        logic [31:0] ea;
        logic [31:0] val;
        logic [31:0] pa32;
        logic [4:0]  dst;
        logic        do_wr;
        logic [2:0]  size;
        logic signed [63:0] ps;
        logic [63:0] pu;

        a    = fwd(r_b.src_a_index, rf_a, c_wr, r_d_wr);
        b    = fwd(r_b.src_b_index, rf_b, c_wr, r_d_wr);
        pc4  = r_pc + 32'd4;
        npc  = pc4;
        simm = {{16{r_b.immediate[15]}}, r_b.immediate};
        zimm = {16'd0, r_b.immediate};
        ea   = a + simm;
        pa32 = {24'd0, r_b.preload_address};
        val  = '0;
        dst  = r_b.dest_index;
        do_wr = 1'b0;
        size = 3'd4;
        ps   = $signed(a) * $signed(b);
        pu   = 64'(a) * 64'(b);

        res = '0;
        res.next_pc = r_pc;
        res.halted  = r_halt;
        n_pc   = r_pc;
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_mp   = r_mp;
        n_halt = r_halt;
        n_c_kind = CK_NONE;
        n_c_op   = r_b.req_type;
        n_c_addr = r_b.src_b_index;
        n_c_data = b;
        n_c_ealo = ea[1:0];
        n_c_idx  = ea[IDXW+1:2];
        mem_rd   = 1'b0;

        if (!r_b_valid) begin
            n_c_kind = CK_NONE;
        end else if (r_b.req_type == OP_PRELOAD) begin
            if (pa32 < 32'(MEM_WORDS)) begin
                n_c_kind = CK_PRELOAD;
                n_c_data = r_b.preload_word;
                n_c_idx  = pa32[IDXW-1:0];
            end
        end else if (r_b.req_type == OP_START) begin
            n_hi   = '0;
            n_lo   = '0;
            n_mp   = 1'b0;
            n_halt = 1'b0;
            n_pc   = r_pc_start;
            n_c_kind = CK_START;
            n_c_data = r_sp_start;
            res.next_pc = r_pc_start;
            res.halted  = 1'b0;
        end else if (r_b.req_type > OP_START || r_halt) begin
            n_c_kind = CK_NONE;
        end else begin
            case (r_b.req_type)
                OP_ADD: begin
                    val = a + b;
                    res.err_overflow = (~(a ^ b) & (a ^ val)) >> 31 != 0;
                    do_wr = 1'b1;
                end
                OP_ADDU: begin
                    val = a + b;
                    do_wr = 1'b1;
                end
                OP_SUB: begin
                    val = a + (32'd0 - b);
                    res.err_overflow = ((~(a ^ (32'd0 - b)) & (a ^ val)) >> 31) != 0;
                    do_wr = 1'b1;
                end
                OP_AND:  begin val = a & b;       do_wr = 1'b1; end
                OP_OR:   begin val = a | b;       do_wr = 1'b1; end
                OP_XOR:  begin val = a ^ b;       do_wr = 1'b1; end
                OP_NOR:  begin val = ~(a | b);    do_wr = 1'b1; end
                OP_NAND: begin val = ~(a & b);    do_wr = 1'b1; end
                OP_SLT: begin
                    val = {31'd0, $signed(a) < $signed(b)};
                    do_wr = 1'b1;
                end
                OP_SLL: begin
                    val = b << r_b.shift_amount;
                    if (r_b.dest_index == 5'd0) begin
                        res.err_write_zero = !(r_b.src_b_index == 5'd0 &&
                                               r_b.shift_amount == 5'd0);
                    end else begin
                        do_wr = 1'b1;
                    end
                end
                OP_SRL: begin val = b >> r_b.shift_amount; do_wr = 1'b1; end
                OP_SRA: begin
                    val = $unsigned($signed(b) >>> r_b.shift_amount);
                    do_wr = 1'b1;
                end
                OP_JR: begin
                    npc = a;
                    res.pc_redirected = 1'b1;
                end
                OP_MULT, OP_MULTU: begin
                    res.err_hilo_overwrite = r_mp;
                    if (r_b.req_type == OP_MULT) begin
                        n_hi = ps[63:32];
                        n_lo = ps[31:0];
                    end else begin
                        n_hi = pu[63:32];
                        n_lo = pu[31:0];
                    end
                    n_mp = 1'b1;
                end
                OP_MFHI: begin n_mp = 1'b0; val = r_hi; do_wr = 1'b1; end
                OP_MFLO: begin n_mp = 1'b0; val = r_lo; do_wr = 1'b1; end
                OP_ADDI: begin
                    val = ea;
                    res.err_overflow = ((~(a ^ simm) & (a ^ ea)) >> 31) != 0;
                    dst = r_b.src_b_index;
                    do_wr = 1'b1;
                end
                OP_ADDIU: begin
                    val = ea;
                    dst = r_b.src_b_index;
                    do_wr = 1'b1;
                end
                OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB: begin
                    if (r_b.req_type == OP_LW || r_b.req_type == OP_SW) begin
                        size = 3'd4;
                    end else if (r_b.req_type == OP_LH || r_b.req_type == OP_LHU ||
                                 r_b.req_type == OP_SH) begin
                        size = 3'd2;
                    end else begin
                        size = 3'd1;
                    end
                    res.effective_address = ea;
                    res.err_overflow = ((~(a ^ simm) & (a ^ ea)) >> 31) != 0;
                    res.err_address_range = ({1'b0, ea} + 33'(size)) > 33'(MEM_BYTES);
                    res.err_misaligned = (ea[1:0] & (size[1:0] - 2'd1)) != 2'd0;
                    if (r_b.req_type <= OP_LBU && r_b.src_b_index == 5'd0) begin
                        res.err_write_zero = 1'b1;
                    end
                    if (res.err_address_range || res.err_misaligned) begin
                        n_halt = 1'b1;
                    end else begin
                        mem_rd = 1'b1;
                        if (r_b.req_type >= OP_SW) begin
                            n_c_kind = CK_STORE;
                        end else if (r_b.src_b_index != 5'd0) begin
                            n_c_kind = CK_LOAD;
                        end
                    end
                end
                OP_LUI: begin
                    val = {r_b.immediate, 16'd0};
                    dst = r_b.src_b_index;
                    do_wr = 1'b1;
                end
                OP_ANDI: begin val = a & zimm; dst = r_b.src_b_index; do_wr = 1'b1; end
                OP_ORI:  begin val = a | zimm; dst = r_b.src_b_index; do_wr = 1'b1; end
                OP_NORI: begin
                    val = ~(a | zimm);
                    dst = r_b.src_b_index;
                    do_wr = 1'b1;
                end
                OP_SLTI: begin
                    val = {31'd0, $signed(a) < $signed(simm)};
                    dst = r_b.src_b_index;
                    do_wr = 1'b1;
                end
                OP_BEQ: begin
                    if (a == b) begin
                        npc = pc4 + (simm << 2);
                        res.pc_redirected = 1'b1;
                    end
                end
                OP_BNE: begin
                    if (a != b) begin
                        npc = pc4 + (simm << 2);
                        res.pc_redirected = 1'b1;
                    end
                end
                OP_BGTZ: begin
                    if (a != 32'd0 && !a[31]) begin
                        npc = pc4 + (simm << 2);
                        res.pc_redirected = 1'b1;
                    end
                end
                OP_J: begin
                    npc = {pc4[31:28], r_b.jump_target, 2'b00};
                    res.pc_redirected = 1'b1;
                end
                OP_JAL: begin
                    npc = {pc4[31:28], r_b.jump_target, 2'b00};
                    res.pc_redirected = 1'b1;
                    val = pc4;
                    dst = RA_REG;
                    do_wr = 1'b1;
                end
                default: begin
                    npc = pc4;
                end
            endcase
            if (do_wr) begin
                if (dst == 5'd0) begin
                    res.err_write_zero = 1'b1;
                end else begin
                    n_c_kind = CK_REG;
                    n_c_addr = dst;
                    n_c_data = val;
                end
            end
            n_pc = npc;
            res.next_pc = npc;
            res.halted  = n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_hi   <= '0;
            r_lo   <= '0;
            r_mp   <= 1'b0;
            r_halt <= 1'b0;
            r_c_kind <= CK_NONE;
        end else begin
            r_pc   <= n_pc;
            r_hi   <= n_hi;
            r_lo   <= n_lo;
            r_mp   <= n_mp;
            r_halt <= n_halt;
            r_c_kind <= n_c_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_op   <= n_c_op;
        r_c_addr <= n_c_addr;
        r_c_data <= n_c_data;
        r_c_ealo <= n_c_ealo;
        r_c_idx  <= n_c_idx;
    end

    // Memory step: register write-back, load extraction, preload writes and read-modify-write of sub-word stores.
    always_comb begin
        logic [31:0] word;
        logic [4:0]  sh;
        logic [31:0] part;

        word = (r_dm_valid && r_dm_idx == r_c_idx) ? r_dm_data : r_mem_q;
        if (r_c_op == OP_LW || r_c_op == OP_SW) begin
            sh = 5'd0;
        end else if (r_c_op == OP_LH || r_c_op == OP_LHU || r_c_op == OP_SH) begin
            sh = r_c_ealo[1] ? 5'd0 : 5'd16;
        end else begin
            sh = {~r_c_ealo, 3'b000};
        end
        part = word >> sh;

        c_wr = '0;
        c_wr.addr = r_c_addr;
        c_wr.data = r_c_data;
        mem_we    = 1'b0;
        mem_waddr = r_c_idx;
        mem_wdata = r_c_data;

        case (r_c_kind)
            CK_REG: begin
                c_wr.en = 1'b1;
            end
            CK_START: begin
                c_wr.start = 1'b1;
            end
            CK_LOAD: begin
                c_wr.en = 1'b1;
                case (r_c_op)
                    OP_LH:   c_wr.data = {{16{part[15]}}, part[15:0]};
                    OP_LHU:  c_wr.data = {16'd0, part[15:0]};
                    OP_LB:   c_wr.data = {{24{part[7]}}, part[7:0]};
                    OP_LBU:  c_wr.data = {24'd0, part[7:0]};
                    default: c_wr.data = word;
                endcase
            end
            CK_STORE: begin
                mem_we = 1'b1;
                case (r_c_op)
                    OP_SH: mem_wdata = (word & ~(32'h0000_FFFF << sh)) |
                                       ({16'd0, r_c_data[15:0]} << sh);
                    OP_SB: mem_wdata = (word & ~(32'h0000_00FF << sh)) |
                                       ({24'd0, r_c_data[7:0]} << sh);
                    default: mem_wdata = r_c_data;
                endcase
            end
            CK_PRELOAD: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_wr     <= '0;
            r_dm_valid <= 1'b0;
        end else begin
            r_d_wr     <= c_wr;
            r_dm_valid <= mem_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dm_idx  <= mem_waddr;
        r_dm_data <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_active <= 1'b1;
            r_clear_idx    <= '0;
        end else if (r_clear_active) begin
            r_clear_idx <= r_clear_idx + 1'b1;
            if (r_clear_idx == IDXW'(MEM_WORDS - 1)) begin
                r_clear_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clear_active) begin
            r_dmem[r_clear_idx] <= '0;
        end else if (mem_we) begin
            r_dmem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd) begin
            r_mem_q <= r_dmem[n_c_idx];
        end
    end

    // Output queue.
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_out_valid = r_count != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (r_b_valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNTW'(r_b_valid) - CNTW'(out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    assign o_next_pc            = r_fifo[r_rd_ptr].next_pc;
    assign o_pc_redirected      = r_fifo[r_rd_ptr].pc_redirected;
    assign o_effective_address  = r_fifo[r_rd_ptr].effective_address;
    assign o_halted             = r_fifo[r_rd_ptr].halted;
    assign o_err_write_zero     = r_fifo[r_rd_ptr].err_write_zero;
    assign o_err_overflow       = r_fifo[r_rd_ptr].err_overflow;
    assign o_err_hilo_overwrite = r_fifo[r_rd_ptr].err_hilo_overwrite;
    assign o_err_address_range  = r_fifo[r_rd_ptr].err_address_range;
    assign o_err_misaligned     = r_fifo[r_rd_ptr].err_misaligned;

    `MSEU_ASSERT_ALWAYS(a_queue_bound, i_clk, i_rst_n, r_count <= CNTW'(OUT_DEPTH), "output queue overflow")
    `MSEU_ASSERT_ALWAYS(a_no_accept_in_clear, i_clk, i_rst_n, !(in_acc && r_clear_active), "transaction accepted during memory clear")
    `MSEU_ASSERT_ALWAYS(a_no_zero_write, i_clk, i_rst_n, !(c_wr.en && c_wr.addr == 5'd0), "register zero written")
    `MSEU_ASSERT_NEXT(a_accept_executes, i_clk, i_rst_n, in_acc, r_b_valid, "accepted transaction not executed")

endmodule
`default_nettype wire
